/* rtl/core/vertex_cache_miss_counter_defines.svh */
// Assertion macros for the vertex cache miss counter.
// Both expect signals named clk and rst in the scope of use.
`ifndef VERTEX_CACHE_MISS_COUNTER_DEFINES_SVH
`define VERTEX_CACHE_MISS_COUNTER_DEFINES_SVH

`ifndef ASSERT_OFF

`define VCMC_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define VCMC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define VCMC_ASSERT_IMPLIES(name, ante, cons, msg)

`define VCMC_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

/* rtl/core/vcmc_pkg.sv */
package vcmc_pkg;

  localparam int VERTEX_W            = 16;
  localparam int STAMP_W             = 32;
  localparam int COUNT_W             = 32;
  localparam int CFG_DATA_W          = 6;
  localparam int CFG_INDEX_W         = 1;
  // Wide enough for a cell number at the largest supported cache size.
  localparam int IDX_FIELD_W         = 6;
  localparam int DEFAULT_MAX_ENTRIES = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_CACHE_ENTRIES = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_LRU_MODE      = 1'b1;

  localparam logic [CFG_DATA_W-1:0]  CACHE_ENTRIES_RESET = 6'd32;
  localparam logic                   LRU_MODE_RESET      = 1'b1;

  // Lookup word as it travels down the row of cells.
  typedef struct packed {
    logic                   valid;
    logic [VERTEX_W-1:0]    vertex;
    logic                   found;
    logic [IDX_FIELD_W-1:0] hit_idx;
    logic                   have_best;
    logic [IDX_FIELD_W-1:0] best_idx;
    logic                   best_valid;
    logic [STAMP_W-1:0]     best_stamp;
  } probe_t;

  // Update broadcast to every cell.
  typedef struct packed {
    logic                   en;
    logic                   clear;
    logic [IDX_FIELD_W-1:0] idx;
    logic [VERTEX_W-1:0]    vertex;
    logic [STAMP_W-1:0]     stamp;
  } entry_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // An invalid entry ranks below every valid one; valid entries rank by stamp.
  function automatic logic ranks_below(input logic a_valid, input logic [STAMP_W-1:0] a_stamp,
                                       input logic b_valid, input logic [STAMP_W-1:0] b_stamp);
    logic below;
    if (!a_valid) begin
      below = b_valid;
    end else begin
      below = b_valid && (a_stamp < b_stamp);
    end
    return below;
  endfunction

endpackage

/* rtl/core/vcmc_in_if.sv */
interface vcmc_in_if import vcmc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] vertex_index;
  logic                end_of_run;

  modport source (output valid, output vertex_index, output end_of_run, input ready);
  modport sink   (input valid, input vertex_index, input end_of_run, output ready);
endinterface

/* rtl/core/vcmc_out_if.sv */
interface vcmc_out_if import vcmc_pkg::*;;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [COUNT_W-1:0] miss_count;
  logic               run_done;

  modport source (output valid, output hit, output miss_count, output run_done, input ready);
  modport sink   (input valid, input hit, input miss_count, input run_done, output ready);
endinterface

/* rtl/core/vcmc_cell.sv */
module vcmc_cell import vcmc_pkg::*; #(
  parameter int CELL_ID = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  probe_t    probe_in,
  input  entry_wr_t wr,
  output probe_t    probe_out
);

  localparam logic [IDX_FIELD_W-1:0] SELF_ID = IDX_FIELD_W'(CELL_ID);

  logic [VERTEX_W-1:0] entry_vertex;
  logic                entry_valid;
  logic [STAMP_W-1:0]  entry_stamp;
  probe_t              probe_next;
  logic                wr_sel;

  assign wr_sel = wr.en && (wr.idx == SELF_ID);

  always_comb begin
    probe_next = probe_in;
    if (!probe_in.found && entry_valid && (entry_vertex == probe_in.vertex)) begin
      probe_next.found   = 1'b1;
      probe_next.hit_idx = SELF_ID;
    end
    // Strictly below keeps the lowest-numbered entry on a tie.
    if (!probe_in.have_best ||
        ranks_below(entry_valid, entry_stamp, probe_in.best_valid, probe_in.best_stamp)) begin
      probe_next.have_best  = 1'b1;
      probe_next.best_idx   = SELF_ID;
      probe_next.best_valid = entry_valid;
      probe_next.best_stamp = entry_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (wr.clear) begin
      entry_valid <= 1'b0;
    end else if (wr_sel) begin
      entry_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      entry_vertex <= wr.vertex;
      entry_stamp  <= wr.stamp;
    end
  end

endmodule

/* rtl/core/vertex_cache_miss_counter.sv */
// Fully associative vertex cache simulator: each word carries a 16-bit vertex index and returns
// one result word with the hit flag, the saturating miss count of the run so far and a copy of
// end_of_run. The cache is a row of cells, one entry each; a lookup word walks down the row one
// cell per cycle, collecting the first matching entry and the replacement victim as it goes.
// A new word is accepted only once the previous one has finished the following steps, where n is the
// effective cache_entries value (0 reads as 1, values above MAX_ENTRIES as MAX_ENTRIES): the
// walk down the first n cells of the row, the capture of the outcome, and the update of the chosen
// cell with the load of the result register. A result waiting to be taken stalls only the update
// step. Reset clears all valid bits at once, so no clearing pass is needed. Write configuration
// only while the block is idle.
`include "vertex_cache_miss_counter_defines.svh"

module vertex_cache_miss_counter import vcmc_pkg::*; #(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  vcmc_in_if.sink                lookup,
  vcmc_out_if.source             result
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NUM_W = CFG_DATA_W + 1;

  logic [CFG_DATA_W-1:0] cache_entries;
  logic                  lru_mode;
  logic [NUM_W-1:0]      n_eff;
  logic [IDX_W-1:0]      last_idx;

  state_t             state;
  probe_t             res;
  logic               end_flag;
  logic [STAMP_W-1:0] item_counter;
  logic [COUNT_W-1:0] miss_total;
  logic [COUNT_W-1:0] miss_next;
  logic               out_valid;
  logic               out_free;
  logic               accept;
  logic               update;
  entry_wr_t          wr;
  probe_t             chain_in  [MAX_ENTRIES];
  probe_t             chain_out [MAX_ENTRIES];
  probe_t             end_probe;
  logic [MAX_ENTRIES-1:0] token_vec;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_entries <= CACHE_ENTRIES_RESET;
      lru_mode      <= LRU_MODE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CACHE_ENTRIES: cache_entries <= cfg_data;
        REG_LRU_MODE:      lru_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cache_entries == '0) begin
      n_eff = NUM_W'(1);
    end else if ({1'b0, cache_entries} > NUM_W'(MAX_ENTRIES)) begin
      n_eff = NUM_W'(MAX_ENTRIES);
    end else begin
      n_eff = {1'b0, cache_entries};
    end
  end

  assign last_idx = IDX_W'(n_eff - NUM_W'(1));

  // Row of cells. The word is dropped after the last cell in use.
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    if (k == 0) begin : g_head
      always_comb begin
        chain_in[k]        = '0;
        chain_in[k].valid  = accept;
        chain_in[k].vertex = lookup.vertex_index;
      end
    end else begin : g_link
      always_comb begin
        chain_in[k]       = chain_out[k-1];
        chain_in[k].valid = chain_out[k-1].valid && (last_idx != IDX_W'(k - 1));
      end
    end

    vcmc_cell #(
      .CELL_ID (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (chain_in[k]),
      .wr        (wr),
      .probe_out (chain_out[k])
    );

    assign token_vec[k] = chain_out[k].valid;
  end

  assign end_probe = chain_out[last_idx];

  assign out_free      = !out_valid || result.ready;
  assign accept        = lookup.valid && lookup.ready;
  assign lookup.ready  = (state == ST_IDLE);
  assign update        = (state == ST_DONE) && out_free;

  assign miss_next = (!res.found && (miss_total != '1)) ? miss_total + COUNT_W'(1) : miss_total;

  always_comb begin
    wr        = '0;
    wr.en     = update && (!res.found || lru_mode);
    wr.clear  = update && end_flag;
    wr.idx    = res.found ? res.hit_idx : res.best_idx;
    wr.vertex = res.vertex;
    wr.stamp  = item_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (accept) begin
          state <= ST_SCAN;
        end
        ST_SCAN: if (end_probe.valid) begin
          state <= ST_DONE;
        end
        ST_DONE: if (out_free) begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      end_flag <= lookup.end_of_run;
    end
    if ((state == ST_SCAN) && end_probe.valid) begin
      res <= end_probe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_counter <= '0;
      miss_total   <= '0;
    end else if (update) begin
      item_counter <= end_flag ? '0 : item_counter + STAMP_W'(1);
      miss_total   <= end_flag ? '0 : miss_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (update) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      result.hit        <= res.found;
      result.miss_count <= miss_next;
      result.run_done   <= end_flag;
    end
  end

  assign result.valid = out_valid;

  `VCMC_ASSERT_IMPLIES(a_single_word, 1'b1, $onehot0(token_vec), "More than one word in the row")
  `VCMC_ASSERT_NEXT(a_accept_enters_row, accept, (state == ST_SCAN) && token_vec[0], "Accepted word did not enter the first cell")
  `VCMC_ASSERT_IMPLIES(a_done_row_empty, state == ST_DONE, token_vec == '0, "Word still in the row after capture")

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vcmc_pkg::*;

  localparam int CAPACITY       = DEFAULT_MAX_ENTRIES;
  localparam int LONG_HOLD      = 200;
  localparam int TAIL_CYCLES    = 2 * CAPACITY + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 90;

  typedef struct {
    logic [VERTEX_W-1:0] vertex;
    logic                last;
  } lookup_word_t;

  typedef struct {
    logic               hit;
    logic [COUNT_W-1:0] miss_count;
    logic               run_done;
  } result_word_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  vcmc_in_if  lookup_ch ();
  vcmc_out_if result_ch ();

  vertex_cache_miss_counter #(
    .MAX_ENTRIES(CAPACITY)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .lookup   (lookup_ch),
    .result   (result_ch)
  );

  // Predicted contents of the cache and the current register settings.
  logic [VERTEX_W-1:0]   cache_vertex [CAPACITY];
  logic                  cache_valid  [CAPACITY];
  logic [STAMP_W-1:0]    cache_stamp  [CAPACITY];
  logic [STAMP_W-1:0]    lookup_no;
  logic [COUNT_W-1:0]    run_misses;
  logic [CFG_DATA_W-1:0] size_reg;
  logic                  lru_reg;

  lookup_word_t pending_lookups [$];
  result_word_t expected_results [$];

  bit src_idle_on;
  bit snk_idle_on;
  int src_gap;
  int snk_gap;
  int snk_hold;
  int holds_wanted;
  int holds_served;

  int failures;
  int lookups_sent;
  int results_checked;
  int hits_seen;
  int runs_seen;
  int settings_used;

  function automatic void wipe_cache();
    for (int k = 0; k < CAPACITY; k++) begin
      cache_vertex[k] = '0;
      cache_valid[k]  = 1'b0;
      cache_stamp[k]  = '0;
    end
    lookup_no  = '0;
    run_misses = '0;
  endfunction

  function automatic int entries_in_use(input logic [CFG_DATA_W-1:0] size);
    if (size == 0) return 1;
    if (size > CAPACITY) return CAPACITY;
    return int'(size);
  endfunction

  function automatic result_word_t lookup_vertex(input lookup_word_t w);
    result_word_t r;
    int n;
    int slot;
    bit found;
    n = entries_in_use(size_reg);
    found = 1'b0;
    slot = 0;
    for (int k = 0; k < n; k++) begin
      if (!found && cache_valid[k] && cache_vertex[k] == w.vertex) begin
        found = 1'b1;
        slot = k;
      end
    end
    if (found) begin
      if (lru_reg) cache_stamp[slot] = lookup_no;
    end else begin
      // An empty entry always loses to a filled one; ties keep the lowest entry.
      slot = 0;
      for (int k = 1; k < n; k++) begin
        if (!cache_valid[k] ? cache_valid[slot]
                            : (cache_valid[slot] && cache_stamp[k] < cache_stamp[slot]))
          slot = k;
      end
      cache_vertex[slot] = w.vertex;
      cache_valid[slot]  = 1'b1;
      cache_stamp[slot]  = lookup_no;
      if (run_misses != '1) run_misses = run_misses + 1'b1;
    end
    r.hit        = found;
    r.miss_count = run_misses;
    r.run_done   = w.last;
    lookup_no = lookup_no + 1'b1;
    if (w.last) wipe_cache();
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sender: an offered word is held until taken; gaps only start between words.
  always @(posedge clk) begin
    lookup_word_t taken_w;
    bit took;
    bit show;
    if (rst) begin
      lookup_ch.valid        <= 1'b0;
      lookup_ch.vertex_index <= '0;
      lookup_ch.end_of_run   <= 1'b0;
      src_gap = 0;
    end else begin
      took = lookup_ch.valid && lookup_ch.ready;
      if (took) begin
        taken_w = pending_lookups.pop_front();
        expected_results.push_back(lookup_vertex(taken_w));
        lookups_sent++;
      end
      show = 1'b0;
      if (lookup_ch.valid && !took) begin
        show = 1'b1;
      end else if (src_gap > 0) begin
        src_gap--;
      end else if (pending_lookups.size() != 0) begin
        if (src_idle_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(0, 12);
        else show = 1'b1;
      end
      lookup_ch.valid <= show;
      if (show) begin
        lookup_ch.vertex_index <= pending_lookups[0].vertex;
        lookup_ch.end_of_run   <= pending_lookups[0].last;
      end
    end
  end

  // Receiver: checks each word against the oldest prediction, then picks its next ready.
  always @(posedge clk) begin
    result_word_t want;
    bit rdy;
    if (rst) begin
      result_ch.ready <= 1'b0;
      snk_gap = 0;
      snk_hold = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: hit=%0d miss_count=%0d run_done=%0d",
                 result_ch.hit, result_ch.miss_count, result_ch.run_done);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (result_ch.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, result_ch.hit);
            failures++;
          end
          if (result_ch.miss_count !== want.miss_count) begin
            $error("miss_count: expected %0d, actual %0d", want.miss_count,
                   result_ch.miss_count);
            failures++;
          end
          if (result_ch.run_done !== want.run_done) begin
            $error("run_done: expected %0d, actual %0d", want.run_done, result_ch.run_done);
            failures++;
          end
          results_checked++;
          if (want.hit) hits_seen++;
          if (want.run_done) runs_seen++;
        end
      end
      rdy = 1'b0;
      if (snk_hold > 0) begin
        snk_hold--;
      end else if (holds_served != holds_wanted) begin
        holds_served++;
        snk_hold = LONG_HOLD - 1;
      end else if (snk_gap > 0) begin
        snk_gap--;
      end else if (snk_idle_on && $urandom_range(0, 4) == 0) begin
        snk_gap = $urandom_range(0, 12);
      end else begin
        rdy = 1'b1;
      end
      result_ch.ready <= rdy;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((lookup_ch.valid && lookup_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("testbench: errors");
    $finish;
  end

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_CACHE_ENTRIES) size_reg = data;
    else lru_reg = data[0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_lookup(input logic [VERTEX_W-1:0] vertex, input logic last);
    lookup_word_t w;
    w.vertex = vertex;
    w.last   = last;
    pending_lookups.push_back(w);
  endtask

  // Waits until every word has gone through and the block has settled.
  task automatic drain();
    while (pending_lookups.size() != 0 || expected_results.size() != 0 || snk_hold != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Runs reuse a small pool of nearby indices so that hits and evictions both happen.
  task automatic queue_random_runs(input int count, input int n, input bit close_last);
    int left;
    int run_len;
    int pool;
    logic [VERTEX_W-1:0] base;
    logic [VERTEX_W-1:0] v;
    left = count;
    while (left > 0) begin
      run_len = $urandom_range(1, 4 * n + 10);
      if (run_len > left) run_len = left;
      pool = $urandom_range(1, n + 6);
      base = VERTEX_W'($urandom);
      for (int k = 0; k < run_len; k++) begin
        case ($urandom_range(0, 19))
          0:       v = $urandom_range(0, 1) ? '0 : '1;
          1, 2:    v = VERTEX_W'($urandom);
          default: v = base + VERTEX_W'($urandom_range(0, pool - 1));
        endcase
        queue_lookup(v, ((k == run_len - 1) && (close_last || left > run_len))
                        || $urandom_range(0, 39) == 0);
      end
      left -= run_len;
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] sz;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_CACHE_ENTRIES;
    cfg_data <= '0;
    size_reg = CACHE_ENTRIES_RESET;
    lru_reg = LRU_MODE_RESET;
    wipe_cache();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    holds_wanted = 0;
    holds_served = 0;
    failures = 0;
    lookups_sent = 0;
    results_checked = 0;
    hits_seen = 0;
    runs_seen = 0;
    settings_used = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings; an index of zero must miss while the entries are still empty.
    queue_lookup(16'h0000, 1'b0);
    queue_lookup(16'h0000, 1'b0);
    queue_lookup(16'hFFFF, 1'b0);
    queue_lookup(16'hFFFF, 1'b0);
    queue_lookup(16'h5555, 1'b0);
    queue_lookup(16'hAAAA, 1'b0);
    queue_lookup(16'h0000, 1'b0);
    queue_lookup(16'hAAAA, 1'b1);
    queue_lookup(16'h0000, 1'b1);
    drain();

    // A size of zero behaves as a single entry.
    set_reg(REG_CACHE_ENTRIES, 6'd0);
    queue_lookup(16'd7, 1'b0);
    queue_lookup(16'd7, 1'b0);
    queue_lookup(16'd8, 1'b0);
    queue_lookup(16'd7, 1'b1);
    drain();

    // Insertion order: a hit does not save the oldest entry from eviction.
    set_reg(REG_CACHE_ENTRIES, 6'd2);
    set_reg(REG_LRU_MODE, 6'd0);
    queue_lookup(16'd1, 1'b0);
    queue_lookup(16'd2, 1'b0);
    queue_lookup(16'd1, 1'b0);
    queue_lookup(16'd3, 1'b0);
    queue_lookup(16'd1, 1'b1);
    drain();

    // Shrinking mid-run hides the upper entries; growing again brings them back.
    set_reg(REG_CACHE_ENTRIES, 6'd4);
    set_reg(REG_LRU_MODE, 6'd1);
    queue_lookup(16'd10, 1'b0);
    queue_lookup(16'd11, 1'b0);
    queue_lookup(16'd12, 1'b0);
    queue_lookup(16'd13, 1'b0);
    drain();
    set_reg(REG_CACHE_ENTRIES, 6'd2);
    queue_lookup(16'd12, 1'b0);
    drain();
    set_reg(REG_CACHE_ENTRIES, 6'd4);
    queue_lookup(16'd13, 1'b0);
    queue_lookup(16'd12, 1'b1);
    drain();
    settings_used += 4;

    // The receiver holds off while the sender keeps offering, so the block backs up.
    set_reg(REG_CACHE_ENTRIES, 6'd1);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    holds_wanted++;
    queue_random_runs(40, 1, 1'b1);
    drain();
    settings_used++;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       sz = 6'd1;
        1:       sz = 6'd32;
        2:       sz = 6'd0;
        3:       sz = 6'd63;
        4:       sz = 6'd33;
        5:       sz = 6'd2;
        8:       sz = 6'd4;
        10:      sz = 6'd32;
        default: sz = CFG_DATA_W'($urandom_range(2, 31));
      endcase
      set_reg(REG_CACHE_ENTRIES, sz);
      set_reg(REG_LRU_MODE, CFG_DATA_W'($urandom_range(0, 63)));
      src_idle_on = (p < RANDOM_PHASES - 2) && $urandom_range(0, 3) != 0;
      snk_idle_on = (p < RANDOM_PHASES - 2) && $urandom_range(0, 3) != 0;
      // Some phases leave a run open so that the next size applies to a live cache.
      queue_random_runs(PHASE_ITEMS, entries_in_use(sz), $urandom_range(0, 2) != 0);
      drain();
      settings_used++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d lookups sent, %0d results checked (%0d hits, %0d runs closed)",
             lookups_sent, results_checked, hits_seen, runs_seen);
    $display("summary: %0d cache settings, both replacement modes, one long output stall",
             settings_used);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
